// ===== hw/rtl/ata_pkg.sv =====
// Shared types, constants and the operation step table of the affine transform accumulator.
`timescale 1ns / 1ps

package ata_pkg;

  localparam int COEF_W     = 32;
  localparam int ACC_W      = 34;
  localparam int NUM_COEF   = 6;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int FUNC_W     = 3;
  localparam int ANGLE_W    = 16;
  localparam int STEP_IDX_W = 3;

  localparam int XY_W      = 34;
  localparam int Z_W       = 36;
  localparam int ATAN_W    = 30;
  localparam int MAX_STEPS = 30;
  localparam int STEP_W    = 5;

  localparam logic signed [Z_W-1:0]  Z_PI      = 36'sd3373259426;
  localparam logic signed [Z_W-1:0]  Z_HALF_PI = 36'sd1686629713;
  localparam logic signed [XY_W-1:0] XY_GAIN   = 34'sd652032875;

  localparam logic [ATAN_W-1:0] ATAN_Q30 [MAX_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
    30'd31, 30'd15, 30'd8, 30'd4, 30'd2
  };

  localparam logic [FUNC_W-1:0] FN_RESET     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_TRANSLATE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SCALE     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ROTATE    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SHEAR     = 3'd4;

  typedef logic [2:0] cidx_t;

  localparam cidx_t C00 = 3'd0;
  localparam cidx_t C01 = 3'd1;
  localparam cidx_t C02 = 3'd2;
  localparam cidx_t C10 = 3'd3;
  localparam cidx_t C11 = 3'd4;
  localparam cidx_t C12 = 3'd5;

  typedef enum logic [2:0] {
    B_X   = 3'd0,
    B_Y   = 3'd1,
    B_COS = 3'd2,
    B_SIN = 3'd3,
    B_ONE = 3'd4
  } bsel_t;

  typedef struct packed {
    cidx_t a_idx;
    bsel_t b_sel;
    logic  neg;
    logic  first;
    logic  last;
    cidx_t dest;
    logic  stop;
  } step_t;

  function automatic step_t mk_step(cidx_t a, bsel_t b, logic ng, logic fst, logic lst,
                                    cidx_t d, logic stp);
    step_t s;
    s.a_idx = a;
    s.b_sel = b;
    s.neg   = ng;
    s.first = fst;
    s.last  = lst;
    s.dest  = d;
    s.stop  = stp;
    return s;
  endfunction

  // Each step multiplies one old coefficient by one operand and adds the rounded product into
  // the running sum (subtracts it if neg is set); the last step of a group writes the saturated sum back.
  function automatic step_t step_rom(logic [FUNC_W-1:0] func, logic [STEP_IDX_W-1:0] idx);
    step_t s;
    s = '0;
    case (func)
      FN_TRANSLATE: begin
        case (idx)
          3'd0:    s = mk_step(C00, B_X,   1'b0, 1'b1, 1'b0, C02, 1'b0);
          3'd1:    s = mk_step(C01, B_Y,   1'b0, 1'b0, 1'b0, C02, 1'b0);
          3'd2:    s = mk_step(C02, B_ONE, 1'b0, 1'b0, 1'b1, C02, 1'b0);
          3'd3:    s = mk_step(C10, B_X,   1'b0, 1'b1, 1'b0, C12, 1'b0);
          3'd4:    s = mk_step(C11, B_Y,   1'b0, 1'b0, 1'b0, C12, 1'b0);
          default: s = mk_step(C12, B_ONE, 1'b0, 1'b0, 1'b1, C12, 1'b1);
        endcase
      end
      FN_SCALE: begin
        case (idx)
          3'd0:    s = mk_step(C00, B_X, 1'b0, 1'b1, 1'b1, C00, 1'b0);
          3'd1:    s = mk_step(C01, B_Y, 1'b0, 1'b1, 1'b1, C01, 1'b0);
          3'd2:    s = mk_step(C10, B_X, 1'b0, 1'b1, 1'b1, C10, 1'b0);
          default: s = mk_step(C11, B_Y, 1'b0, 1'b1, 1'b1, C11, 1'b1);
        endcase
      end
      FN_ROTATE: begin
        case (idx)
          3'd0:    s = mk_step(C00, B_COS, 1'b0, 1'b1, 1'b0, C00, 1'b0);
          3'd1:    s = mk_step(C01, B_SIN, 1'b1, 1'b0, 1'b1, C00, 1'b0);
          3'd2:    s = mk_step(C00, B_SIN, 1'b0, 1'b1, 1'b0, C01, 1'b0);
          3'd3:    s = mk_step(C01, B_COS, 1'b0, 1'b0, 1'b1, C01, 1'b0);
          3'd4:    s = mk_step(C10, B_COS, 1'b0, 1'b1, 1'b0, C10, 1'b0);
          3'd5:    s = mk_step(C11, B_SIN, 1'b1, 1'b0, 1'b1, C10, 1'b0);
          3'd6:    s = mk_step(C10, B_SIN, 1'b0, 1'b1, 1'b0, C11, 1'b0);
          default: s = mk_step(C11, B_COS, 1'b0, 1'b0, 1'b1, C11, 1'b1);
        endcase
      end
      FN_SHEAR: begin
        case (idx)
          3'd0:    s = mk_step(C00, B_ONE, 1'b0, 1'b1, 1'b0, C00, 1'b0);
          3'd1:    s = mk_step(C01, B_Y,   1'b0, 1'b0, 1'b1, C00, 1'b0);
          3'd2:    s = mk_step(C01, B_ONE, 1'b0, 1'b1, 1'b0, C01, 1'b0);
          3'd3:    s = mk_step(C00, B_X,   1'b0, 1'b0, 1'b1, C01, 1'b0);
          3'd4:    s = mk_step(C10, B_ONE, 1'b0, 1'b1, 1'b0, C10, 1'b0);
          3'd5:    s = mk_step(C11, B_Y,   1'b0, 1'b0, 1'b1, C10, 1'b0);
          3'd6:    s = mk_step(C11, B_ONE, 1'b0, 1'b1, 1'b0, C11, 1'b0);
          default: s = mk_step(C10, B_X,   1'b0, 1'b0, 1'b1, C11, 1'b1);
        endcase
      end
      default: s = mk_step(C00, B_ONE, 1'b0, 1'b1, 1'b1, C00, 1'b1);
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/ata_mul.sv =====
// Shared fixed-point multiplier with a product register, rounding and saturation.
`timescale 1ns / 1ps

module ata_mul
  import ata_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic signed [COEF_W-1:0] a,
  input  logic signed [COEF_W-1:0] b,
  output logic signed [COEF_W-1:0] res
);

  localparam logic signed [PROD_W-1:0] RND = PROD_W'((64'd1 << FRAC_BITS) >> 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sd2147483648);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] shifted;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  always_comb begin
    shifted = (prod_r + RND) >>> FRAC_BITS;
    if (shifted > SAT_MAX) begin
      res = SAT_MAX[COEF_W-1:0];
    end else if (shifted < SAT_MIN) begin
      res = SAT_MIN[COEF_W-1:0];
    end else begin
      res = shifted[COEF_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/ata_cordic.sv =====
// Iterative CORDIC unit that returns the sine and cosine of a Q3.12 angle.
`timescale 1ns / 1ps

module ata_cordic
  import ata_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                      done,
  output logic signed [COEF_W-1:0]  sin_q,
  output logic signed [COEF_W-1:0]  cos_q
);

  localparam int SHIFT = 30 - FRAC_BITS;
  localparam logic signed [XY_W-1:0] RND = XY_W'((64'd1 << SHIFT) >> 1);
  localparam logic signed [XY_W-1:0] ONE_XY = XY_W'(64'd1 << FRAC_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_RED  = 4'b0010,
    C_ITER = 4'b0100,
    C_FIN  = 4'b1000
  } cstate_t;

  cstate_t                  state_r, state_nxt;
  logic signed [Z_W-1:0]    z_r, z_nxt;
  logic signed [XY_W-1:0]   x_r, x_nxt;
  logic signed [XY_W-1:0]   y_r, y_nxt;
  logic                     neg_r, neg_nxt;
  logic [STEP_W-1:0]        i_r, i_nxt;
  logic                     done_r;
  logic signed [COEF_W-1:0] sin_r, cos_r;
  logic signed [XY_W-1:0]   x_sh, y_sh;
  logic signed [Z_W-1:0]    atan_z;
  logic signed [XY_W-1:0]   x_fin, y_fin;

  function automatic logic signed [COEF_W-1:0] to_q(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    r = (v + RND) >>> SHIFT;
    if (r > ONE_XY) begin
      r = ONE_XY;
    end else if (r < -ONE_XY) begin
      r = -ONE_XY;
    end
    return r[COEF_W-1:0];
  endfunction

  always_comb begin
    x_sh   = x_r >>> i_r;
    y_sh   = y_r >>> i_r;
    atan_z = $signed({{(Z_W - ATAN_W){1'b0}}, ATAN_Q30[i_r]});
    x_fin  = neg_r ? -x_r : x_r;
    y_fin  = neg_r ? -y_r : y_r;
  end

  always_comb begin
    state_nxt = state_r;
    z_nxt     = z_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    neg_nxt   = neg_r;
    i_nxt     = i_r;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          z_nxt     = $signed({{(Z_W - ANGLE_W - 18){angle[ANGLE_W-1]}}, angle, 18'b0});
          x_nxt     = XY_GAIN;
          y_nxt     = '0;
          neg_nxt   = 1'b0;
          i_nxt     = '0;
          state_nxt = C_RED;
        end
      end
      C_RED: begin
        if (z_r > Z_HALF_PI) begin
          z_nxt   = z_r - Z_PI;
          neg_nxt = ~neg_r;
        end else if (z_r < -Z_HALF_PI) begin
          z_nxt   = z_r + Z_PI;
          neg_nxt = ~neg_r;
        end else begin
          state_nxt = C_ITER;
        end
      end
      C_ITER: begin
        if (!z_r[Z_W-1]) begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - atan_z;
        end else begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + atan_z;
        end
        if (i_r == LAST_STEP) begin
          state_nxt = C_FIN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      C_FIN: begin
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == C_FIN);
    end
  end

  always_ff @(posedge clk) begin
    z_r   <= z_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    neg_r <= neg_nxt;
    i_r   <= i_nxt;
    if (state_r == C_FIN) begin
      cos_r <= to_q(x_fin);
      sin_r <= to_q(y_fin);
    end
  end

  assign done  = done_r;
  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

// ===== hw/rtl/affine_transform_accumulator.sv =====
// Top level of the affine transform accumulator: sequencer, coefficient store and result register.
//
//   Channel  Direction  Transfer condition       Payload
//   in_      input      in_valid && !in_stall    func, x_value, y_value, angle
//   out_     output     out_valid && !out_stall  c00 c01 c02 c10 c11 c12, identity_flag
//
// From the input transfer, reset and unused codes go straight to the done state; translate, scale
// and shear issue their steps to the multiplier; rotate first waits for the CORDIC unit, whose
// run depends on how many half turns the angle reduction takes.
// The rate is set by the CORDIC iterations and the single shared multiplier, one product a cycle.
// rst_n is synchronous; reset loads the identity matrix and empties the result register.
// A new item is taken while a result waits in the output register; the next result waits
// in turn until that one has been taken.
`timescale 1ns / 1ps

module affine_transform_accumulator
  import ata_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic signed [COEF_W-1:0]  in_x_value,
  input  logic signed [COEF_W-1:0]  in_y_value,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COEF_W-1:0]  out_c00,
  output logic signed [COEF_W-1:0]  out_c01,
  output logic signed [COEF_W-1:0]  out_c02,
  output logic signed [COEF_W-1:0]  out_c10,
  output logic signed [COEF_W-1:0]  out_c11,
  output logic signed [COEF_W-1:0]  out_c12,
  output logic                      out_identity_flag
);

  localparam logic signed [COEF_W-1:0] ONE = COEF_W'(64'd1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0]  ACC_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0]  ACC_MIN = -ACC_W'(64'sd2147483648);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CORD  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [FUNC_W-1:0]        func_r;
  logic signed [COEF_W-1:0] x_r, y_r;
  logic signed [COEF_W-1:0] coef_r [NUM_COEF];
  logic signed [COEF_W-1:0] old_r [NUM_COEF];
  logic [STEP_IDX_W-1:0]    step_r, step_nxt;
  step_t                    step;
  step_t                    term_r;
  logic                     term_valid_r, term_valid_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, acc_base, term_ext;
  logic signed [COEF_W-1:0] acc_sat;
  logic signed [COEF_W-1:0] mul_a, mul_b, mul_res;
  logic signed [COEF_W-1:0] sin_q, cos_q;
  logic                     cord_start, cord_done;
  logic                     in_accept, out_load, ident;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [COEF_W-1:0] out_coef_r [NUM_COEF];
  logic                     out_ident_r;

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cord_start = in_accept && (in_func == FN_ROTATE);
  assign step       = step_rom(func_r, step_r);

  ata_cordic #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cord_start),
    .angle(in_angle),
    .done (cord_done),
    .sin_q(sin_q),
    .cos_q(cos_q)
  );

  always_comb begin
    mul_a = old_r[step.a_idx];
    case (step.b_sel)
      B_X:     mul_b = x_r;
      B_Y:     mul_b = y_r;
      B_COS:   mul_b = cos_q;
      B_SIN:   mul_b = sin_q;
      default: mul_b = ONE;
    endcase
  end

  ata_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .res(mul_res)
  );

  always_comb begin
    term_ext = ACC_W'(mul_res);
    acc_base = term_r.first ? '0 : acc_r;
    acc_nxt  = term_r.neg ? (acc_base - term_ext) : (acc_base + term_ext);
    if (acc_nxt > ACC_MAX) begin
      acc_sat = ACC_MAX[COEF_W-1:0];
    end else if (acc_nxt < ACC_MIN) begin
      acc_sat = ACC_MIN[COEF_W-1:0];
    end else begin
      acc_sat = acc_nxt[COEF_W-1:0];
    end
  end

  always_comb begin
    ident = (coef_r[C00] == ONE) && (coef_r[C11] == ONE) && (coef_r[C01] == '0) &&
            (coef_r[C02] == '0) && (coef_r[C10] == '0) && (coef_r[C12] == '0);
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    term_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_accept) begin
          if (in_func == FN_ROTATE) begin
            state_nxt = S_CORD;
          end else if ((in_func == FN_TRANSLATE) || (in_func == FN_SCALE) ||
                       (in_func == FN_SHEAR)) begin
            state_nxt = S_ISSUE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CORD: begin
        if (cord_done) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        term_valid_nxt = 1'b1;
        if (step.stop) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      term_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_r[k] <= '0;
      end
      coef_r[C00] <= ONE;
      coef_r[C11] <= ONE;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      term_valid_r <= term_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (in_accept && (in_func == FN_RESET)) begin
        for (int k = 0; k < NUM_COEF; k++) begin
          coef_r[k] <= '0;
        end
        coef_r[C00] <= ONE;
        coef_r[C11] <= ONE;
      end else if (term_valid_r && term_r.last) begin
        coef_r[term_r.dest] <= acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r <= in_func;
      x_r    <= in_x_value;
      y_r    <= in_y_value;
      for (int k = 0; k < NUM_COEF; k++) begin
        old_r[k] <= coef_r[k];
      end
    end
    term_r <= step;
    if (term_valid_r) begin
      acc_r <= acc_nxt;
    end
    if (out_load) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        out_coef_r[k] <= coef_r[k];
      end
      out_ident_r <= ident;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_c00           = out_coef_r[C00];
  assign out_c01           = out_coef_r[C01];
  assign out_c02           = out_coef_r[C02];
  assign out_c10           = out_coef_r[C10];
  assign out_c11           = out_coef_r[C11];
  assign out_c12           = out_coef_r[C12];
  assign out_identity_flag = out_ident_r;

  a_drain_has_term: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> term_valid_r)
    else $error("The last product is not being accumulated while draining.");

  a_term_in_issue: assert property (@(posedge clk) disable iff (!rst_n)
    term_valid_r |-> ((state_r == S_ISSUE) || (state_r == S_DRAIN)))
    else $error("A product is accumulated outside the issue phase.");

  a_cordic_waited: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> (state_r == S_CORD))
    else $error("The CORDIC unit finished while the sequencer was not waiting for it.");

  a_reset_identity: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (func_r == FN_RESET)) |-> ident)
    else $error("The matrix is not the identity after a reset operation.");

endmodule
